// File: sv/hcat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcat_pkg
// Shared types and constants of the HCI connection address tracker.
// ----------------------------------------------------------------------------
package hcat_pkg;

  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned MaxPacketDef    = 1028;

  localparam int unsigned SizeW = 11;
  localparam int unsigned AddrW = 48;
  localparam int unsigned HandleW = 16;

  localparam logic [7:0] TYPE_EVENT    = 8'h04;
  localparam logic [7:0] TYPE_ACL      = 8'h02;
  localparam logic [7:0] EVT_LE_META   = 8'h3E;
  localparam logic [7:0] SUB_CONN_DONE = 8'h01;
  localparam logic [7:0] EVT_DISCONN   = 8'h05;
  localparam logic [7:0] EVT_STATUS_OK = 8'h00;

  localparam logic [15:0] LE_CONN_LEN     = 16'd19;
  localparam logic [15:0] DISCONN_LEN     = 16'd4;
  localparam logic [15:0] ACL_HANDLE_MASK = 16'h0FFF;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_LOOKUP
  } op_e;

  typedef enum logic [1:0] {
    S_COLLECT,
    S_SCAN,
    S_FINISH
  } state_e;

  // Summary of one finished packet, handed from the parser to the table.
  typedef struct packed {
    logic [7:0]         kind;
    logic [SizeW-1:0]   size;
    op_e                op;
    logic [1:0]         status;
    logic [HandleW-1:0] key;
    logic [AddrW-1:0]   address;
  } pkt_t;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [AddrW-1:0]   address;
  } entry_t;

  typedef struct packed {
    logic [7:0]       kind;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] address;
    logic             found;
    logic [1:0]       status;
  } result_t;

endpackage

// File: sv/hcat_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcat_in_if
// Byte channel into the tracker: one packet byte and its end marker per word.
// ----------------------------------------------------------------------------
interface hcat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: sv/hcat_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcat_out_if
// Result channel of the tracker: one word per packet.
// ----------------------------------------------------------------------------
interface hcat_out_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               kind_of_packet;
  logic [hcat_pkg::SizeW-1:0] payload_size;
  logic [hcat_pkg::AddrW-1:0] peer_address;
  logic                     address_found;
  logic [1:0]               status;

  modport source (output valid, output kind_of_packet, output payload_size,
                  output peer_address, output address_found, output status,
                  input ready);
  modport sink   (input valid, input kind_of_packet, input payload_size,
                  input peer_address, input address_found, input status,
                  output ready);
endinterface

// File: sv/hci_connection_address_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hci_connection_address_tracker
// Follows HCI connection events and tags ACL packets with their peer address.
// ----------------------------------------------------------------------------
// Packet bytes are taken one word per cycle, type byte first, and every
// packet gives one result word. Packets that need the connection table
// (a well-formed LE connection complete with status zero, a well-formed
// disconnection complete, or a well-formed ACL packet) are followed by a
// scan of the entry memory, one entry read per cycle, and after such a last
// byte the input is held off until the scan ends and its result word is
// written; other packets do not hold off the input. Entry valid bits
// live in flip-flops cleared by reset, so no clearing pass is needed. A
// result word waits in an output register; the next packet's bytes keep
// flowing meanwhile, and only its last byte waits for that register.
module hci_connection_address_tracker #(
  parameter int unsigned TABLE_ENTRIES = hcat_pkg::TableEntriesDef,
  parameter int unsigned MAX_PACKET    = hcat_pkg::MaxPacketDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcat_in_if.sink    in_i,
  hcat_out_if.source out_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [CntW-1:0] EntryCnt = CntW'(TABLE_ENTRIES);

  hcat_pkg::state_e  state_q, state_d;
  hcat_pkg::pkt_t    pkt, pkt_q;
  hcat_pkg::entry_t  mem [TABLE_ENTRIES];
  hcat_pkg::entry_t  rd_q;
  hcat_pkg::result_t res_q, res_d;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic                     res_valid_q, res_valid_d;
  logic [CntW-1:0]          rd_cnt_q, rd_cnt_d;
  logic                     cmp_valid_q;
  logic [IdxW-1:0]          cmp_idx_q;
  logic                     match_q, match_d;
  logic [IdxW-1:0]          match_idx_q, match_idx_d;
  logic [hcat_pkg::AddrW-1:0] match_addr_q, match_addr_d;
  logic                     free_q, free_d;
  logic [IdxW-1:0]          free_idx_q, free_idx_d;

  logic            res_free;
  logic            in_ready;
  logic            in_fire;
  logic            pkt_done;
  logic            start_scan;
  logic            direct_fire;
  logic            rd_en;
  logic            scan_done;
  logic            finish_fire;
  logic            hit;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;

  hcat_parser #(
    .MAX_PACKET(MAX_PACKET)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_fire),
    .data_byte_i(in_i.data_byte),
    .last_byte_i(in_i.last_byte),
    .pkt_o      (pkt)
  );

  // The output register is free when empty or drained in this cycle.
  assign res_free  = !res_valid_q || out_o.ready;
  assign in_fire   = in_i.valid && in_ready;
  assign pkt_done  = in_fire && in_i.last_byte;
  assign scan_done = cmp_valid_q && (cmp_idx_q == LastIdx);
  assign hit       = cmp_valid_q && valid_q[cmp_idx_q] && (rd_q.handle == pkt_q.key);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      hcat_pkg::S_COLLECT: begin
        if (pkt_done && pkt.op != hcat_pkg::OP_NONE) begin
          state_d = hcat_pkg::S_SCAN;
        end
      end
      hcat_pkg::S_SCAN: begin
        if (scan_done) begin
          state_d = hcat_pkg::S_FINISH;
        end
      end
      hcat_pkg::S_FINISH: begin
        if (res_free) begin
          state_d = hcat_pkg::S_COLLECT;
        end
      end
      default: state_d = hcat_pkg::S_COLLECT;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready    = 1'b0;
    start_scan  = 1'b0;
    direct_fire = 1'b0;
    rd_en       = 1'b0;
    finish_fire = 1'b0;
    case (state_q)
      hcat_pkg::S_COLLECT: begin
        // Only a last byte needs room in the output register.
        in_ready    = res_free || !in_i.last_byte;
        start_scan  = pkt_done && (pkt.op != hcat_pkg::OP_NONE);
        direct_fire = pkt_done && (pkt.op == hcat_pkg::OP_NONE);
      end
      hcat_pkg::S_SCAN: begin
        rd_en = rd_cnt_q < EntryCnt;
      end
      hcat_pkg::S_FINISH: begin
        finish_fire = res_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Scan bookkeeping: the first matching valid entry and the lowest free one.
  always_comb begin
    rd_cnt_d     = rd_cnt_q;
    match_d      = match_q;
    match_idx_d  = match_idx_q;
    match_addr_d = match_addr_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    if (start_scan) begin
      rd_cnt_d = '0;
      match_d  = 1'b0;
      free_d   = 1'b0;
    end else begin
      if (rd_en) begin
        rd_cnt_d = rd_cnt_q + CntW'(1);
      end
      if (hit && !match_q) begin
        match_d      = 1'b1;
        match_idx_d  = cmp_idx_q;
        match_addr_d = rd_q.address;
      end
      if (cmp_valid_q && !valid_q[cmp_idx_q] && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
  end

  // Table update at the end of a scan, and the result word of every packet.
  always_comb begin
    valid_d = valid_q;
    wr_en   = 1'b0;
    wr_idx  = match_q ? match_idx_q : free_idx_q;
    res_d   = res_q;
    if (direct_fire) begin
      res_d.kind    = pkt.kind;
      res_d.size    = pkt.size;
      res_d.address = '0;
      res_d.found   = 1'b0;
      res_d.status  = pkt.status;
    end else if (finish_fire) begin
      res_d.kind    = pkt_q.kind;
      res_d.size    = pkt_q.size;
      res_d.address = '0;
      res_d.found   = 1'b0;
      res_d.status  = hcat_pkg::STATUS_OK;
      case (pkt_q.op)
        hcat_pkg::OP_INSERT: begin
          if (match_q || free_q) begin
            wr_en = 1'b1;
            if (!match_q) begin
              valid_d[free_idx_q] = 1'b1;
            end
          end else begin
            res_d.status = hcat_pkg::STATUS_FULL;
          end
        end
        hcat_pkg::OP_REMOVE: begin
          if (match_q) begin
            valid_d[match_idx_q] = 1'b0;
          end
        end
        hcat_pkg::OP_LOOKUP: begin
          if (match_q) begin
            res_d.address = match_addr_q;
            res_d.found   = 1'b1;
          end
        end
        default: begin
          res_d.status = hcat_pkg::STATUS_OK;
        end
      endcase
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (direct_fire || finish_fire) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= '{handle: pkt_q.key, address: pkt_q.address};
    end
    if (rd_en) begin
      rd_q <= mem[rd_cnt_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      pkt_q <= pkt;
    end
    if (direct_fire || finish_fire) begin
      res_q <= res_d;
    end
    match_idx_q  <= match_idx_d;
    match_addr_q <= match_addr_d;
    free_idx_q   <= free_idx_d;
    cmp_idx_q    <= rd_cnt_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hcat_pkg::S_COLLECT;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
      rd_cnt_q    <= '0;
      cmp_valid_q <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      res_valid_q <= res_valid_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_valid_q <= rd_en;
      match_q     <= match_d;
      free_q      <= free_d;
    end
  end

  assign in_i.ready           = in_ready;
  assign out_o.valid          = res_valid_q;
  assign out_o.kind_of_packet = res_q.kind;
  assign out_o.payload_size   = res_q.size;
  assign out_o.peer_address   = res_q.address;
  assign out_o.address_found  = res_q.found;
  assign out_o.status         = res_q.status;

endmodule

// File: sv/hcat_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcat_parser
// Collects the fields of one HCI packet and classifies it at its last byte.
// ----------------------------------------------------------------------------
module hcat_parser #(
  parameter int unsigned MAX_PACKET = hcat_pkg::MaxPacketDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  output hcat_pkg::pkt_t     pkt_o
);

  localparam int unsigned PosW = $clog2(MAX_PACKET);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_PACKET - 1);
  localparam int unsigned LenW = 17;

  logic                          awaiting_q, awaiting_d;
  logic                          overlong_q, overlong_d;
  logic [PosW-1:0]               pos_q, pos_d;
  logic [7:0]                    held_type_q, held_type_d;
  logic [7:0]                    event_code_q, event_code_d;
  logic [15:0]                   decl_len_q, decl_len_d;
  logic [7:0]                    sub_event_q, sub_event_d;
  logic [7:0]                    event_status_q, event_status_d;
  logic [hcat_pkg::HandleW-1:0]  handle_q, handle_d;
  logic [hcat_pkg::AddrW-1:0]    address_q, address_d;
  logic [LenW-1:0]               size_w;

  always_comb begin
    awaiting_d     = awaiting_q;
    overlong_d     = overlong_q;
    pos_d          = pos_q;
    held_type_d    = held_type_q;
    event_code_d   = event_code_q;
    decl_len_d     = decl_len_q;
    sub_event_d    = sub_event_q;
    event_status_d = event_status_q;
    handle_d       = handle_q;
    address_d      = address_q;
    if (accept_i) begin
      if (awaiting_q) begin
        held_type_d    = data_byte_i;
        pos_d          = '0;
        overlong_d     = 1'b0;
        event_code_d   = '0;
        decl_len_d     = '0;
        sub_event_d    = '0;
        event_status_d = '0;
        handle_d       = '0;
        address_d      = '0;
      end else begin
        if (held_type_q == hcat_pkg::TYPE_ACL) begin
          if (pos_q == PosW'(0)) begin
            handle_d[7:0] = data_byte_i;
          end else if (pos_q == PosW'(1)) begin
            handle_d[15:8] = data_byte_i;
          end else if (pos_q == PosW'(2)) begin
            decl_len_d[7:0] = data_byte_i;
          end else if (pos_q == PosW'(3)) begin
            decl_len_d[15:8] = data_byte_i;
          end
        end else if (held_type_q == hcat_pkg::TYPE_EVENT) begin
          if (pos_q == PosW'(0)) begin
            event_code_d = data_byte_i;
          end else if (pos_q == PosW'(1)) begin
            decl_len_d = {8'h00, data_byte_i};
          end else if (event_code_q == hcat_pkg::EVT_LE_META) begin
            if (pos_q == PosW'(2)) begin
              sub_event_d = data_byte_i;
            end else if (pos_q == PosW'(3)) begin
              event_status_d = data_byte_i;
            end else if (pos_q == PosW'(4)) begin
              handle_d[7:0] = data_byte_i;
            end else if (pos_q == PosW'(5)) begin
              handle_d[15:8] = data_byte_i;
            end else if (pos_q >= PosW'(8) && pos_q <= PosW'(13)) begin
              // Offsets 8 to 13 map onto address lanes 0 to 5.
              address_d[{pos_q[2:0], 3'b000} +: 8] = data_byte_i;
            end
          end else if (event_code_q == hcat_pkg::EVT_DISCONN) begin
            if (pos_q == PosW'(2)) begin
              event_status_d = data_byte_i;
            end else if (pos_q == PosW'(3)) begin
              handle_d[7:0] = data_byte_i;
            end else if (pos_q == PosW'(4)) begin
              handle_d[15:8] = data_byte_i;
            end
          end
        end
        if (pos_q >= PosMax) begin
          overlong_d = 1'b1;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
      awaiting_d = last_byte_i;
    end
  end

  // Classification of the packet as it stands after the current byte.
  always_comb begin
    size_w         = LenW'(pos_d);
    pkt_o.kind     = held_type_d;
    pkt_o.size     = hcat_pkg::SizeW'(pos_d);
    pkt_o.op       = hcat_pkg::OP_NONE;
    pkt_o.status   = hcat_pkg::STATUS_OK;
    pkt_o.key      = handle_d;
    pkt_o.address  = address_d;
    if (overlong_d) begin
      pkt_o.status = hcat_pkg::STATUS_MALFORMED;
    end else if (held_type_d == hcat_pkg::TYPE_EVENT) begin
      if (size_w < LenW'(2) || (size_w - LenW'(2)) != LenW'(decl_len_d)) begin
        pkt_o.status = hcat_pkg::STATUS_MALFORMED;
      end else if (event_code_d == hcat_pkg::EVT_LE_META &&
                   sub_event_d == hcat_pkg::SUB_CONN_DONE) begin
        if (decl_len_d != hcat_pkg::LE_CONN_LEN) begin
          pkt_o.status = hcat_pkg::STATUS_MALFORMED;
        end else if (event_status_d == hcat_pkg::EVT_STATUS_OK) begin
          pkt_o.op = hcat_pkg::OP_INSERT;
        end
      end else if (event_code_d == hcat_pkg::EVT_DISCONN) begin
        if (decl_len_d != hcat_pkg::DISCONN_LEN) begin
          pkt_o.status = hcat_pkg::STATUS_MALFORMED;
        end else begin
          pkt_o.op = hcat_pkg::OP_REMOVE;
        end
      end
    end else if (held_type_d == hcat_pkg::TYPE_ACL) begin
      if (size_w < LenW'(8) || (size_w - LenW'(4)) != LenW'(decl_len_d)) begin
        pkt_o.status = hcat_pkg::STATUS_MALFORMED;
      end else begin
        pkt_o.op  = hcat_pkg::OP_LOOKUP;
        pkt_o.key = handle_d & hcat_pkg::ACL_HANDLE_MASK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q     <= 1'b1;
      overlong_q     <= 1'b0;
      pos_q          <= '0;
      held_type_q    <= '0;
      event_code_q   <= '0;
      decl_len_q     <= '0;
      sub_event_q    <= '0;
      event_status_q <= '0;
      handle_q       <= '0;
      address_q      <= '0;
    end else begin
      awaiting_q     <= awaiting_d;
      overlong_q     <= overlong_d;
      pos_q          <= pos_d;
      held_type_q    <= held_type_d;
      event_code_q   <= event_code_d;
      decl_len_q     <= decl_len_d;
      sub_event_q    <= sub_event_d;
      event_status_q <= event_status_d;
      handle_q       <= handle_d;
      address_q      <= address_d;
    end
  end

endmodule

// File: sv/hcat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcat_checker
// Port-level checks on the result channel of the tracker.
// ----------------------------------------------------------------------------
module hcat_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [7:0]                 kind_i,
  input logic [hcat_pkg::SizeW-1:0] size_i,
  input logic [hcat_pkg::AddrW-1:0] addr_i,
  input logic                       found_i,
  input logic [1:0]                 status_i
);

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(size_i) && $stable(addr_i) && $stable(found_i) && $stable(status_i))
    else $error("result word changed while stalled");

  // Without a match the address reads as zero.
  a_no_match_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !found_i |-> addr_i == '0)
    else $error("address without a match");

  // Only a good ACL packet can match.
  a_match_acl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && found_i |-> kind_i == hcat_pkg::TYPE_ACL &&
    status_i == hcat_pkg::STATUS_OK)
    else $error("match on a packet that is not a good ACL packet");

  // A full table only turns away connection events.
  a_full_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == hcat_pkg::STATUS_FULL |->
    kind_i == hcat_pkg::TYPE_EVENT && !found_i)
    else $error("table full reported on a non-event packet");

endmodule

bind hci_connection_address_tracker hcat_checker u_hcat_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .kind_i     (out_o.kind_of_packet),
  .size_i     (out_o.payload_size),
  .addr_i     (out_o.peer_address),
  .found_i    (out_o.address_found),
  .status_i   (out_o.status)
);
